### src/iff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iff_pkg: shared constants and types for the integer field formatter
// Widths of the transaction fields and the digit glyph lookup.
// ----------------------------------------------------------------------------
package iff_pkg;

  localparam int ValueBits  = 32;
  localparam int MaxField   = 64;
  localparam int DigitSlots = 10;   // decimal digits of a 32-bit magnitude
  localparam int CountBits  = 4;
  localparam int FieldBits  = 7;
  localparam int PrecBits   = 6;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;

  // Emission phases of the output sequencer.
  localparam logic [2:0] PhaseIdle  = 3'd0;
  localparam logic [2:0] PhasePad   = 3'd1;
  localparam logic [2:0] PhaseSign  = 3'd2;
  localparam logic [2:0] PhaseZero  = 3'd3;
  localparam logic [2:0] PhaseDigit = 3'd4;

  typedef logic [3:0] digit_t;

  function automatic logic [7:0] glyph(input digit_t d);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else c = 8'h57 + {4'd0, d};
    return c;
  endfunction

endpackage
`default_nettype wire

### src/integer_field_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_field_formatter: printf-style %d / %x field renderer
// Converts one 32-bit value into a padded ASCII field, one character per
// output transaction, with tlast on the final character.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                                | tlast
// s_axis  | in  | is_hex, value[31:0], field_width[6:0],            | -
//         |     | has_precision, precision[5:0], zero fill to 48b   |
// m_axis  | out | out_char[7:0]                                     | last
//
// An item passes a twelve-stage front end (magnitude, ten digit stages that
// peel at most one digit each by divide-by-radix, then field sizing). The sequencer
// loads it only while idle, then emits one character per cycle while m_axis
// is not stalled. A field holds N characters (N is 0..64).
// Front-end stages advance whenever the stage ahead is free, so stalls on
// m_axis back up without loss. Reset rst is synchronous and clears all
// valid bits and the sequencer.
// ----------------------------------------------------------------------------
module integer_field_formatter (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // is_hex, value[31:0], field_width[6:0], has_precision, precision[5:0]
  input  wire  [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // out_char[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int NS = iff_pkg::DigitSlots + 2; // stage 0 sign, 1..10 digits, 11 size

  typedef struct packed {
    logic                          is_hex;
    logic                          neg;
    logic [iff_pkg::ValueBits-1:0] mag;
    logic [iff_pkg::FieldBits-1:0] fw;
    logic                          hp;
    logic [iff_pkg::PrecBits-1:0]  pr;
    logic [iff_pkg::CountBits-1:0] cnt;
    logic                          zero_in; // magnitude was zero
  } item_t;

  item_t         st      [NS];
  iff_pkg::digit_t dg    [NS][iff_pkg::DigitSlots];
  logic          vld     [NS];
  logic          adv     [NS];

  // sizing results
  logic [6:0] pad_left, pad_next;
  logic [5:0] zeros_left, zeros_next;
  logic       sign_pending;
  logic [3:0] digit_count;
  logic [6:0] emitted;
  logic [2:0] emit_phase;
  iff_pkg::digit_t digit_store [iff_pkg::DigitSlots];
  logic       busy;

  // input decode
  logic        in_hex, in_neg;
  logic [31:0] in_val;
  assign in_hex = s_axis_tdata[0];
  assign in_val = s_axis_tdata[32:1];
  assign in_neg = !in_hex && in_val[31];

  // pipeline advance: a stage moves when the next slot is free or moving
  logic load;
  always_comb begin
    adv[NS-1] = vld[NS-1] && load;
    for (int i = NS - 2; i >= 0; i--) adv[i] = vld[i] && (!vld[i+1] || adv[i+1]);
  end
  assign s_axis_tready = !vld[0] || adv[0];

  // stage 0: magnitude
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (s_axis_tready) vld[0] <= s_axis_tvalid;
    if (s_axis_tready && s_axis_tvalid) begin
      st[0].is_hex  <= in_hex;
      st[0].neg     <= in_neg;
      st[0].mag     <= in_neg ? (~in_val + 32'd1) : in_val;
      st[0].fw      <= s_axis_tdata[39:33];
      st[0].hp      <= s_axis_tdata[40];
      st[0].pr      <= s_axis_tdata[46:41];
      st[0].cnt     <= '0;
      st[0].zero_in <= (in_val == 32'd0);
    end
  end

  // digit stages: peel at most one digit per stage
  for (genvar g = 1; g <= iff_pkg::DigitSlots; g++) begin : g_dig
    logic [31:0] q;
    logic [3:0]  r;
    logic        take;
    item_t       st_next;
    iff_pkg::digit_t dg_next [iff_pkg::DigitSlots];
    always_comb begin
      if (st[g-1].is_hex) begin
        q = st[g-1].mag >> 4;
        r = st[g-1].mag[3:0];
      end else begin
        q = 32'((64'(st[g-1].mag) * 64'hCCCCCCCD) >> 35);
        r = 4'(st[g-1].mag - 32'(q * 32'd10));
      end
      // first digit unless zero precision meets a zero value, later ones while magnitude remains
      take = (st[g-1].cnt == '0) ? !(st[g-1].hp && st[g-1].pr == '0 && st[g-1].zero_in)
                                 : (st[g-1].mag != '0);
      st_next = st[g-1];
      for (int k = 0; k < iff_pkg::DigitSlots; k++) dg_next[k] = dg[g-1][k];
      if (take) begin
        st_next.mag = q;
        st_next.cnt = st[g-1].cnt + 4'd1;
        dg_next[g-1] = r;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[g] <= 1'b0;
      else if (!vld[g] || adv[g]) vld[g] <= vld[g-1];
      if (adv[g-1]) begin
        st[g] <= st_next;
        for (int k = 0; k < iff_pkg::DigitSlots; k++) dg[g][k] <= dg_next[k];
      end
    end
  end

  // sizing stage
  logic [6:0] body_w, width_w, prec_w;
  logic [6:0] zl_w;
  item_t      size_next;
  always_comb begin
    item_t s;
    s = st[NS-2];
    prec_w = s.hp ? {1'b0, s.pr} : 7'd1;
    zl_w = (prec_w > {3'd0, s.cnt}) ? prec_w - {3'd0, s.cnt} : 7'd0;
    body_w = {6'd0, s.neg} + zl_w + {3'd0, s.cnt};
    width_w = (s.fw > 7'(iff_pkg::MaxField)) ? 7'(iff_pkg::MaxField) : s.fw;
    size_next = s;
    size_next.fw = (width_w > body_w) ? width_w - body_w : 7'd0; // pad
    size_next.pr = 6'(zl_w);
  end
  always_ff @(posedge clk) begin
    if (rst) vld[NS-1] <= 1'b0;
    else if (!vld[NS-1] || adv[NS-1]) vld[NS-1] <= vld[NS-2];
    if (adv[NS-2]) begin
      st[NS-1] <= size_next;
      for (int k = 0; k < iff_pkg::DigitSlots; k++) dg[NS-1][k] <= dg[NS-2][k];
    end
  end
  // unused stage-0 digit vector feeds stage 1
  always_ff @(posedge clk) begin
    for (int k = 0; k < iff_pkg::DigitSlots; k++) dg[0][k] <= '0;
  end

  // emitter
  logic       out_free;
  logic       have_char;
  logic [7:0] ch;
  logic       more;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign busy = (emit_phase != iff_pkg::PhaseIdle);
  assign load = !busy;

  always_comb begin
    have_char = 1'b1;
    ch = iff_pkg::CharSpace;
    case (emit_phase)
      iff_pkg::PhasePad:   ch = iff_pkg::CharSpace;
      iff_pkg::PhaseSign:  ch = iff_pkg::CharMinus;
      iff_pkg::PhaseZero:  ch = iff_pkg::CharZero;
      iff_pkg::PhaseDigit: ch = iff_pkg::glyph(digit_store[digit_count - 4'd1]);
      default:             have_char = 1'b0;
    endcase
    pad_next   = pad_left;
    zeros_next = zeros_left;
    if (emit_phase == iff_pkg::PhasePad) pad_next = pad_left - 7'd1;
    if (emit_phase == iff_pkg::PhaseZero) zeros_next = zeros_left - 6'd1;
    // anything after this character?
    more = 1'b0;
    case (emit_phase)
      iff_pkg::PhasePad:   more = (pad_next != 0) || sign_pending || (zeros_left != 0)
                                 || (digit_count != 0);
      iff_pkg::PhaseSign:  more = (zeros_left != 0) || (digit_count != 0);
      iff_pkg::PhaseZero:  more = (zeros_next != 0) || (digit_count != 0);
      iff_pkg::PhaseDigit: more = (digit_count != 4'd1);
      default:             more = 1'b0;
    endcase
    if (emitted == 7'(iff_pkg::MaxField - 1)) more = 1'b0;
  end

  function automatic logic [2:0] first_phase(input logic [6:0] p, input logic s,
                                             input logic [5:0] z, input logic [3:0] d);
    logic [2:0] f;
    if (p != 0) f = iff_pkg::PhasePad;
    else if (s) f = iff_pkg::PhaseSign;
    else if (z != 0) f = iff_pkg::PhaseZero;
    else if (d != 0) f = iff_pkg::PhaseDigit;
    else f = iff_pkg::PhaseIdle;
    return f;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_phase    <= iff_pkg::PhaseIdle;
      m_axis_tvalid <= 1'b0;
      pad_left      <= '0;
      zeros_left    <= '0;
      sign_pending  <= 1'b0;
      digit_count   <= '0;
      emitted       <= '0;
    end else begin
      if (adv[NS-1]) begin
        if (m_axis_tready) m_axis_tvalid <= 1'b0;
        pad_left     <= st[NS-1].fw;
        zeros_left   <= st[NS-1].pr;
        sign_pending <= st[NS-1].neg;
        digit_count  <= st[NS-1].cnt;
        emitted      <= '0;
        for (int k = 0; k < iff_pkg::DigitSlots; k++) digit_store[k] <= dg[NS-1][k];
        emit_phase <= first_phase(st[NS-1].fw, st[NS-1].neg, st[NS-1].pr, st[NS-1].cnt);
      end else if (have_char && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= ch;
        m_axis_tlast  <= !more;
        emitted       <= emitted + 7'd1;
        if (emit_phase == iff_pkg::PhasePad) pad_left <= pad_next;
        if (emit_phase == iff_pkg::PhaseSign) sign_pending <= 1'b0;
        if (emit_phase == iff_pkg::PhaseZero) zeros_left <= zeros_next;
        if (emit_phase == iff_pkg::PhaseDigit) digit_count <= digit_count - 4'd1;
        if (!more) emit_phase <= iff_pkg::PhaseIdle;
        else if (emit_phase == iff_pkg::PhasePad)
          emit_phase <= first_phase(pad_next, sign_pending, zeros_left, digit_count);
        else if (emit_phase == iff_pkg::PhaseSign)
          emit_phase <= first_phase(7'd0, 1'b0, zeros_left, digit_count);
        else if (emit_phase == iff_pkg::PhaseZero)
          emit_phase <= first_phase(7'd0, 1'b0, zeros_next, digit_count);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a held output transaction keeps its character
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // never more than the field limit before a last character
  a_field_cap: assert property (@(posedge clk) disable iff (rst)
    emitted <= 7'(iff_pkg::MaxField))
    else $error("field longer than limit");
  // sequencer loads only while idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    adv[NS-1] |-> emit_phase == iff_pkg::PhaseIdle)
    else $error("item loaded over a running field");
`endif

endmodule
`default_nettype wire

### tb/sv/integer_field_formatter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_formatter_test: self-checking bench for the field formatter
// Drives %d / %x requests with random width and precision, renders each field
// in a local model and compares every output character and tlast in order.
// ----------------------------------------------------------------------------
module integer_field_formatter_test;

  class field_scoreboard;
    logic [7:0] chars_q[$];
    logic       ends_q[$];
    int         errors;

    // Render one field and queue its characters.
    function void note_request(logic hx, logic [31:0] v, logic [6:0] fw, logic hp,
                               logic [5:0] pr);
      logic [3:0]  digits[20];
      int          ndig, zeros, body, width, pad, n;
      logic        neg;
      logic [31:0] mag;
      logic [7:0]  line[$];
      int          radix;
      neg = !hx && v[31];
      mag = neg ? -v : v;
      radix = hx ? 16 : 10;
      ndig = 0;
      if (!(hp && pr == 0 && mag == 0)) begin
        do begin
          digits[ndig] = 4'(mag % radix);
          mag = mag / radix;
          ndig++;
        end while (mag != 0);
      end
      zeros = (hp ? int'(pr) : 1) - ndig;
      if (zeros < 0) zeros = 0;
      body = int'(neg) + zeros + ndig;
      width = (fw > iff_pkg::MaxField) ? iff_pkg::MaxField : int'(fw);
      pad = (width > body) ? width - body : 0;
      repeat (pad) line.push_back(iff_pkg::CharSpace);
      if (neg) line.push_back(iff_pkg::CharMinus);
      repeat (zeros) line.push_back(iff_pkg::CharZero);
      for (int k = ndig - 1; k >= 0; k--)
        line.push_back(digits[k] < 10 ? 8'h30 + digits[k] : 8'h57 + digits[k]);
      n = (line.size() > iff_pkg::MaxField) ? iff_pkg::MaxField : line.size();
      for (int i = 0; i < n; i++) begin
        chars_q.push_back(line[i]);
        ends_q.push_back(i == n - 1);
      end
    endfunction

    function void check_char(logic [7:0] c, logic l);
      if (chars_q.size() == 0) begin
        $error("out_char expected none actual %h", c);
        errors++;
        return;
      end
      if (c !== chars_q[0]) begin
        $error("out_char expected %h actual %h", chars_q[0], c);
        errors++;
      end
      if (l !== ends_q[0]) begin
        $error("last expected %0d actual %0d", ends_q[0], l);
        errors++;
      end
      void'(chars_q.pop_front());
      void'(ends_q.pop_front());
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  field_scoreboard board = new();
  bit  calm = 0;
  bit  stall_req = 0;
  int  stall_cnt = 0;
  int  quiet = 0;

  integer_field_formatter i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver: random stalls, a long hold-off once asked.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (stall_req && stall_cnt < 400) begin
      stall_cnt <= stall_cnt + 1;
      m_axis_tready <= 0;
    end else m_axis_tready <= calm || ($urandom_range(99) >= 6);
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_char(m_axis_tdata, m_axis_tlast);
  end

  // Watchdog on cycles with no transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(logic hx, logic [31:0] v, logic [6:0] fw, logic hp,
                              logic [5:0] pr);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {1'b0, pr, hp, fw, v, hx};
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(hx, v, fw, hp, pr);
  endtask

  task automatic send_random();
    logic [31:0] v;
    logic [6:0]  fw;
    case ($urandom_range(3))
      0: v = $urandom_range(20);
      1: v = $urandom;
      2: v = -$urandom_range(1000);
      default: v = $urandom_range(99999);
    endcase
    fw = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(16));
    send_request(1'($urandom_range(1)), v, fw, 1'($urandom_range(1)),
                 ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(12)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_request(0, 0, 0, 1, 0);            // empty field
    send_request(1, 0, 5, 1, 0);            // spaces only
    send_request(0, 32'h8000_0000, 0, 0, 0); // most negative
    send_request(0, 32'h8000_0000, 20, 1, 15);
    send_request(0, 32'hffff_ffff, 127, 1, 63); // wide and long
    send_request(1, 32'hffff_ffff, 0, 0, 0);
    send_request(1, 32'hffff_ffff, 3, 1, 63);
    send_request(0, 32'h7fff_ffff, 64, 0, 0);
    send_request(0, 10, 0, 0, 0);
    send_request(1, 16, 0, 0, 0);
    send_request(1, 32'h0abc_def0, 12, 1, 10);
    send_request(0, 0, 0, 0, 0);
    send_request(0, -1, 4, 1, 3);
    send_request(0, 9, 65, 1, 42);
    // Stall the output while requests keep coming.
    stall_req = 1;
    repeat (30) send_random();
    calm = 1;
    repeat (60) send_random();
    calm = 0;
    repeat (260) send_random();
    s_axis_tvalid <= 0;
    while (board.chars_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

### files.f
src/iff_pkg.sv
src/integer_field_formatter.sv
tb/sv/integer_field_formatter_test.sv
